### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mmce_pkg.sv
// types and constants for the multi-mode character encoder
package mmce_pkg;

    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_U16LE = 2'd1;
    localparam logic [1:0] MODE_U16BE = 2'd2;
    localparam logic [1:0] MODE_MUTF8 = 2'd3;

    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [15:0] CH_LF      = 16'h000A;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [15:0] ONE_MIN    = 16'h0001;
    localparam logic [15:0] ONE_MAX    = 16'h007F;
    localparam logic [15:0] TWO_MAX    = 16'h07FF;

    localparam int MAX_BYTES = 4;
    localparam int IDX_W     = 2;

    typedef logic [7:0] byte_t;

    // one character worth of bytes, first byte in slot 0
    typedef struct packed {
        byte_t [MAX_BYTES-1:0] bytes;
        logic [IDX_W-1:0]      last_idx;
    } desc_t;

endpackage

### hw/rtl/mmce_front.sv
// front end: mode register and classification of code units into byte runs
module mmce_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_data,
    input  logic [15:0]     code_unit,
    output mmce_pkg::desc_t desc
);

    logic [1:0] mode_reg;
    logic [1:0] mode_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_valid) begin
            mode_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mmce_pkg::MODE_ASCII;
        end else begin
            mode_reg <= mode_next;
        end
    end

    logic                lf;
    mmce_pkg::byte_t     lo;
    mmce_pkg::byte_t     hi;
    mmce_pkg::byte_t     u8_b0;
    mmce_pkg::byte_t     u8_b1;
    mmce_pkg::byte_t     u8_b2;

    assign lf    = (code_unit == mmce_pkg::CH_LF);
    assign lo    = code_unit[7:0];
    assign hi    = code_unit[15:8];
    assign u8_b0 = mmce_pkg::LEAD3 | {4'b0, code_unit[15:12]};
    assign u8_b1 = mmce_pkg::CONT | {2'b0, code_unit[11:6]};
    assign u8_b2 = mmce_pkg::CONT | {2'b0, code_unit[5:0]};

    always_comb begin
        desc.bytes    = '0;
        desc.last_idx = 2'd0;
        unique case (mode_reg)
            mmce_pkg::MODE_ASCII: begin
                if (lf) begin
                    desc.bytes[0] = mmce_pkg::CH_CR;
                    desc.bytes[1] = lo;
                    desc.last_idx = 2'd1;
                end else begin
                    desc.bytes[0] = lo;
                    desc.last_idx = 2'd0;
                end
            end
            mmce_pkg::MODE_U16LE: begin
                if (lf) begin
                    desc.bytes[0] = mmce_pkg::CH_CR;
                    desc.bytes[1] = 8'h00;
                    desc.bytes[2] = lo;
                    desc.bytes[3] = hi;
                    desc.last_idx = 2'd3;
                end else begin
                    desc.bytes[0] = lo;
                    desc.bytes[1] = hi;
                    desc.last_idx = 2'd1;
                end
            end
            mmce_pkg::MODE_U16BE: begin
                if (lf) begin
                    desc.bytes[0] = 8'h00;
                    desc.bytes[1] = mmce_pkg::CH_CR;
                    desc.bytes[2] = hi;
                    desc.bytes[3] = lo;
                    desc.last_idx = 2'd3;
                end else begin
                    desc.bytes[0] = hi;
                    desc.bytes[1] = lo;
                    desc.last_idx = 2'd1;
                end
            end
            default: begin
                if (code_unit >= mmce_pkg::ONE_MIN && code_unit <= mmce_pkg::ONE_MAX) begin
                    if (lf) begin
                        desc.bytes[0] = mmce_pkg::CH_CR;
                        desc.bytes[1] = lo;
                        desc.last_idx = 2'd1;
                    end else begin
                        desc.bytes[0] = lo;
                        desc.last_idx = 2'd0;
                    end
                end else if (code_unit > mmce_pkg::TWO_MAX) begin
                    desc.bytes[0] = u8_b0;
                    desc.bytes[1] = u8_b1;
                    desc.bytes[2] = u8_b2;
                    desc.last_idx = 2'd2;
                end else begin
                    desc.bytes[0] = mmce_pkg::LEAD2 | {3'b0, code_unit[10:6]};
                    desc.bytes[1] = u8_b2;
                    desc.last_idx = 2'd1;
                end
            end
        endcase
    end

endmodule

### hw/rtl/mmce_queue.sv
// descriptor queue between front end and serializer
module mmce_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mmce_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mmce_pkg::desc_t head
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    mmce_pkg::desc_t mem [DEPTH];
    mmce_pkg::desc_t head_reg;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = head_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head entry is registered, with bypass when it is the one being written
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (do_push && (rd_ptr_next == wr_ptr_reg)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

### hw/rtl/mmce_back.sv
// back end: serializes one byte per cycle into the output register while the queue has an entry and m_ready allows
module mmce_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  mmce_pkg::desc_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_byte
);

    logic [mmce_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       adv;
    logic                       is_last;

    assign adv     = head_valid && (!valid_reg || m_ready);
    assign is_last = (idx_reg == head.last_idx);
    assign pop     = adv && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (adv) begin
            valid_next = 1'b1;
            byte_next  = head.bytes[idx_reg];
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_last_byte = last_reg;

endmodule

### hw/rtl/multi_mode_char_encoder.sv
// top level of the multi-mode character encoder
// Encodes one 16-bit code unit per input transaction as a run of one to four bytes
// (ascii, utf-16 le/be or modified utf-8, set by cfg_data), one byte per output
// transaction with m_last_byte on the final byte. A code unit is accepted whenever
// the descriptor queue (DEPTH entries) has room; the serializer then drives one byte
// per cycle while m_ready does not stall it, and its single output byte per cycle
// sets the sustained rate.
module multi_mode_char_encoder #(
    parameter int DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte
);

    mmce_pkg::desc_t desc;
    mmce_pkg::desc_t head;
    logic            full;
    logic            head_valid;
    logic            pop;

    mmce_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .code_unit (s_code_unit),
        .desc      (desc)
    );

    mmce_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_data  (desc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    assign s_ready = !full;

    mmce_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

### hw/rtl/mmce_checker.sv
// port-level checker for the multi-mode character encoder, with its bind
`include "assert_macros.svh"

module mmce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last_byte
);

    logic       m_stall;
    logic [8:0] m_payload;

    assign m_stall   = m_valid && !m_ready;
    assign m_payload = {m_last_byte, m_out_byte};

    `ASSERT_CLK(a_m_valid_hold, aclk, aresetn, m_stall |=> m_valid, "m_valid dropped")
    `ASSERT_CLK(a_m_data_hold, aclk, aresetn, m_stall |=> $stable(m_payload), "byte changed")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "output valid after reset")
    `ASSERT_CLK(a_cfg_ready, aclk, aresetn, cfg_valid |-> cfg_ready, "config write stalled")

endmodule

bind multi_mode_char_encoder mmce_checker u_mmce_checker (.*);

### tb/tb_multi_mode_char_encoder.sv
// self-checking testbench for the multi-mode character encoder
module tb_multi_mode_char_encoder;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } enc_byte_t;

    typedef struct {
        logic [1:0]      mode;
        logic [15:0]     unit;
        int              count;
        logic [3:0][7:0] bytes;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = mmce_pkg::MODE_ASCII;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_byte;

    enc_byte_t   pending_bytes[$];
    stim_row_t   stim_table[$];
    logic [1:0]  enc_mode = mmce_pkg::MODE_ASCII;
    logic [1:0]  phase_modes [8] = '{mmce_pkg::MODE_MUTF8, mmce_pkg::MODE_U16LE,
                                     mmce_pkg::MODE_ASCII, mmce_pkg::MODE_U16BE,
                                     mmce_pkg::MODE_MUTF8, mmce_pkg::MODE_U16BE,
                                     mmce_pkg::MODE_U16LE, mmce_pkg::MODE_MUTF8};
    int          error_count = 0;
    int          hold_off_len = 0;
    int          rx_style = 1;
    logic [12:0] rx_pattern = 13'b1011001110101;
    int          tx_burst = 0;
    bit          tx_gaps = 1'b1;

    multi_mode_char_encoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int encode_unit(input logic [1:0] mode, input logic [15:0] cu,
                                       output logic [3:0][7:0] run);
        int   n;
        logic lf;
        n = 0;
        run = '0;
        lf = (cu == mmce_pkg::CH_LF);
        case (mode)
            mmce_pkg::MODE_ASCII: begin
                if (lf) begin
                    run[n] = mmce_pkg::CH_CR;
                    n++;
                end
                run[n] = cu[7:0];
                n++;
            end
            mmce_pkg::MODE_U16LE: begin
                if (lf) begin
                    run[0] = mmce_pkg::CH_CR;
                    run[1] = 8'h00;
                    n = 2;
                end
                run[n] = cu[7:0];
                run[n + 1] = cu[15:8];
                n += 2;
            end
            mmce_pkg::MODE_U16BE: begin
                if (lf) begin
                    run[0] = 8'h00;
                    run[1] = mmce_pkg::CH_CR;
                    n = 2;
                end
                run[n] = cu[15:8];
                run[n + 1] = cu[7:0];
                n += 2;
            end
            default: begin
                if (cu >= mmce_pkg::ONE_MIN && cu <= mmce_pkg::ONE_MAX) begin
                    if (lf) begin
                        run[n] = mmce_pkg::CH_CR;
                        n++;
                    end
                    run[n] = cu[7:0];
                    n++;
                end else if (cu > mmce_pkg::TWO_MAX) begin
                    run[0] = mmce_pkg::LEAD3 | {4'h0, cu[15:12]};
                    run[1] = mmce_pkg::CONT | {2'b00, cu[11:6]};
                    run[2] = mmce_pkg::CONT | {2'b00, cu[5:0]};
                    n = 3;
                end else begin
                    run[0] = mmce_pkg::LEAD2 | {3'b000, cu[10:6]};
                    run[1] = mmce_pkg::CONT | {2'b00, cu[5:0]};
                    n = 2;
                end
            end
        endcase
        return n;
    endfunction

    function automatic void expect_run(input int n, input logic [3:0][7:0] run);
        enc_byte_t e;
        for (int i = 0; i < n; i++) begin
            e.value = run[i];
            e.last = (i == n - 1);
            pending_bytes.push_back(e);
        end
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [15:0] unit,
                                    input int n, input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3);
        stim_row_t r;
        r.mode = mode;
        r.unit = unit;
        r.count = n;
        r.bytes = {b3, b2, b1, b0};
        stim_table.push_back(r);
    endfunction

    function automatic logic [15:0] random_unit();
        case ($urandom_range(0, 7))
            0: return mmce_pkg::CH_LF;
            1: begin
                case ($urandom_range(0, 7))
                    0: return 16'h0000;
                    1: return mmce_pkg::ONE_MIN;
                    2: return mmce_pkg::ONE_MAX;
                    3: return 16'h0080;
                    4: return mmce_pkg::TWO_MAX;
                    5: return 16'h0800;
                    6: return 16'hFFFF;
                    default: return 16'h010A;
                endcase
            end
            2, 3: return 16'($urandom_range(0, 127));
            4: return 16'($urandom_range(0, 2047));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int next_gap();
        if (!tx_gaps) return 0;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        tx_burst = $urandom_range(1, 8);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_unit(input logic [15:0] cu, input int gap, input int typed_n,
                             input logic [3:0][7:0] typed_run);
        int              n;
        logic [3:0][7:0] run;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        // payload is held until accepted, so the bytes can be queued now
        if (typed_n > 0) begin
            expect_run(typed_n, typed_run);
        end else begin
            n = encode_unit(enc_mode, cu, run);
            expect_run(n, run);
        end
        s_valid <= 1'b1;
        s_code_unit <= cu;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        enc_mode = mode;
    endtask

    initial begin : byte_checker
        enc_byte_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected transaction: out_byte %h last_byte %b",
                           m_out_byte, m_last_byte);
                    error_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_out_byte !== want.value) begin
                        $error("out_byte expected %h actual %h", want.value, m_out_byte);
                        error_count++;
                    end
                    if (m_last_byte !== want.last) begin
                        $error("last_byte expected %b actual %b", want.last, m_last_byte);
                        error_count++;
                    end
                end
            end
            if (hold_off_len > 0) begin
                m_ready <= 1'b0;
                hold_off_len--;
            end else begin
                case (rx_style)
                    0: m_ready <= 1'b1;
                    1: begin
                        m_ready <= rx_pattern[0];
                        rx_pattern <= {rx_pattern[0], rx_pattern[12:1]};
                    end
                    default: m_ready <= ($urandom_range(0, 9) < 6);
                endcase
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first rows run on the reset mode
        add_row(mmce_pkg::MODE_ASCII, 16'h0041, 1, 8'h41, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_ASCII, mmce_pkg::CH_LF, 2, mmce_pkg::CH_CR, 8'h0A, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_ASCII, 16'h010A, 1, 8'h0A, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_ASCII, 16'hFFFF, 1, 8'hFF, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_ASCII, 16'h0000, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16LE, 16'h1234, 2, 8'h34, 8'h12, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16LE, mmce_pkg::CH_LF, 4, mmce_pkg::CH_CR, 8'h00, 8'h0A, 8'h00);
        add_row(mmce_pkg::MODE_U16LE, 16'hFFFF, 2, 8'hFF, 8'hFF, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16LE, 16'h0000, 2, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16BE, 16'h1234, 2, 8'h12, 8'h34, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16BE, mmce_pkg::CH_LF, 4, 8'h00, mmce_pkg::CH_CR, 8'h00, 8'h0A);
        add_row(mmce_pkg::MODE_U16BE, 16'h0A00, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_U16BE, 16'hA55A, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h0000, 2, 8'hC0, 8'h80, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h0001, 1, 8'h01, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h007F, 1, 8'h7F, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h0080, 2, 8'hC2, 8'h80, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h07FF, 2, 8'hDF, 8'hBF, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h0800, 3, 8'hE0, 8'hA0, 8'h80, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'hFFFF, 3, 8'hEF, 8'hBF, 8'hBF, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'hD800, 3, 8'hED, 8'hA0, 8'h80, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'hDFFF, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, mmce_pkg::CH_LF, 2, mmce_pkg::CH_CR, 8'h0A, 8'h00, 8'h00);
        add_row(mmce_pkg::MODE_MUTF8, 16'h010A, 0, 8'h00, 8'h00, 8'h00, 8'h00);

        foreach (stim_table[i]) begin
            if (stim_table[i].mode != enc_mode) write_mode(stim_table[i].mode);
            send_unit(stim_table[i].unit, next_gap(), stim_table[i].count, stim_table[i].bytes);
        end

        for (int phase = 0; phase < 8; phase++) begin
            write_mode(phase_modes[phase]);
            rx_style = phase % 3;
            tx_gaps = (phase % 4 != 1);
            // back up the output while the input keeps streaming
            if (phase == 1) hold_off_len = 80;
            for (int k = 0; k < 11; k++) begin
                if (phase == 5 && k == 7) wait_drained();
                send_unit(random_unit(), next_gap(), 0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_multi_mode_char_encoder: clean");
        end else begin
            $display("tb_multi_mode_char_encoder: errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_multi_mode_char_encoder: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mmce_pkg.sv
hw/rtl/mmce_front.sv
hw/rtl/mmce_queue.sv
hw/rtl/mmce_back.sv
hw/rtl/multi_mode_char_encoder.sv
hw/rtl/mmce_checker.sv
tb/tb_multi_mode_char_encoder.sv
